[sv/rfd_pkg.sv]
package rfd_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HDR_FIRST  = 1'b0,
    CFG_HDR_SECOND = 1'b1
  } cfg_idx_t;

  localparam logic [7:0] HDR_FIRST_RST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND_RST = 8'h55;

  // Frame layout positions.
  localparam logic [15:0] POS_HDR0     = 16'd0;
  localparam logic [15:0] POS_HDR1     = 16'd1;
  localparam logic [15:0] POS_LEN_HI   = 16'd2;
  localparam logic [15:0] POS_LEN_LO   = 16'd3;
  localparam logic [15:0] POS_CTRL     = 16'd4;
  localparam logic [15:0] POS_FUNC     = 16'd5;
  localparam logic [15:0] POS_TXN      = 16'd6;
  localparam logic [15:0] PAYLOAD_START = 16'd7;
  localparam logic [15:0] MIN_FRAME_BYTES = 16'd8;

  // Control and function byte codes.
  localparam logic [7:0] CTRL_TYPE_MASK   = 8'hC0;
  localparam logic [7:0] CTRL_TYPE_REPORT = 8'h80;
  localparam logic [7:0] FUNC_HEARTBEAT   = 8'h70;
  localparam logic [7:0] FUNC_BOX         = 8'h72;
  localparam logic [7:0] FUNC_QUAD        = 8'h7B;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_SHORT    = 3'd1,
    ST_BAD_HEADER   = 3'd2,
    ST_LEN_OVERRUN  = 3'd3,
    ST_BAD_CHECKSUM = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    RK_NONE      = 3'd0,
    RK_HEARTBEAT = 3'd1,
    RK_BOX       = 3'd2,
    RK_QUAD      = 3'd3,
    RK_OTHER     = 3'd4
  } report_kind_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } item_kind_t;

  // End of frame summary fields.
  typedef struct packed {
    status_t      status;
    logic [1:0]   frame_type;
    report_kind_t report_kind;
    logic [7:0]   function_code;
    logic [7:0]   transaction_id;
    logic [15:0]  payload_length;
  } summary_t;

  // All results caused by one input beat.
  typedef struct packed {
    logic       pay_v;
    logic       sum_v;
    logic [7:0] payload;
    summary_t   summary;
  } grp_t;

  function automatic report_kind_t kind_of_report(input logic [7:0] ctrl,
                                                  input logic [7:0] func);
    report_kind_t k;
    if ((ctrl & CTRL_TYPE_MASK) != CTRL_TYPE_REPORT) begin
      k = RK_NONE;
    end else if (func == FUNC_HEARTBEAT) begin
      k = RK_HEARTBEAT;
    end else if (func == FUNC_BOX) begin
      k = RK_BOX;
    end else if (func == FUNC_QUAD) begin
      k = RK_QUAD;
    end else begin
      k = RK_OTHER;
    end
    return k;
  endfunction

endpackage

[sv/report_frame_deframer.sv]
// Each accepted byte passes the input register, then the output queue, before out_*.
// One byte per cycle while the output queue has room; a final byte that lands in the payload yields
// a payload beat and a summary beat, which go out as two separate output beats.
// A four-group output queue absorbs that burst and output stalls.
// Reset: synchronous, active-low rst_n clears frame state and the queue and
// sets the header markers to 0xAA and 0x55.
module report_frame_deframer #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_rx_byte,
  input  logic                          in_final_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_item_kind,
  output logic [7:0]                    out_payload_byte,
  output logic [2:0]                    out_frame_status,
  output logic [1:0]                    out_frame_type,
  output logic [2:0]                    out_report_kind,
  output logic [7:0]                    out_function_code,
  output logic [7:0]                    out_transaction_id,
  output logic [15:0]                   out_payload_length,
  output logic                          out_last_of_run,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import rfd_pkg::*;

  logic q_ready;
  logic q_push;
  grp_t q_grp;

  // Parser with input register and frame state.
  rfd_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .in_final_byte(in_final_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_grp        (q_grp)
  );

  // Result queue that splits each group into output beats.
  rfd_out_queue u_out_queue (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_push            (q_push),
    .q_grp             (q_grp),
    .q_ready           (q_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item_kind     (out_item_kind),
    .out_payload_byte  (out_payload_byte),
    .out_frame_status  (out_frame_status),
    .out_frame_type    (out_frame_type),
    .out_report_kind   (out_report_kind),
    .out_function_code (out_function_code),
    .out_transaction_id(out_transaction_id),
    .out_payload_length(out_payload_length),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

[sv/rfd_parse.sv]
module rfd_parse #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_rx_byte,
  input  logic                          in_final_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          q_ready,
  output logic                          q_push,
  output rfd_pkg::grp_t                 q_grp
);
  import rfd_pkg::*;

  localparam logic [15:0] MAX_POS = 16'(MAX_FRAME_BYTES);

  // Input register.
  logic       vld_r;
  logic [7:0] byte_r;
  logic       fin_r;
  logic       go;

  // Header registers.
  logic [7:0] hdr_first_r;
  logic [7:0] hdr_second_r;

  // Frame state.
  logic [15:0] pos_r,      pos_nxt;
  logic [15:0] len_r,      len_nxt;
  logic [7:0]  xor_r,      xor_nxt;
  logic        hdr_ok_r,   hdr_ok_nxt;
  logic [7:0]  ctrl_r,     ctrl_nxt;
  logic [7:0]  func_r,     func_nxt;
  logic [7:0]  txn_r,      txn_nxt;
  logic        chk_ok_r,   chk_ok_nxt;
  logic        chk_seen_r, chk_seen_nxt;

  logic        in_range;
  logic        too_short;
  logic [16:0] chk_pos;
  grp_t        grp;

  assign go        = vld_r && q_ready;
  assign in_ready  = !vld_r || go;
  assign cfg_ready = 1'b1;

  // Capture a beat whenever the input register is free or drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
      fin_r  <= in_final_byte;
    end
  end

  // Header marker registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= HDR_FIRST_RST;
      hdr_second_r <= HDR_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HDR_FIRST:  hdr_first_r  <= cfg_data;
        CFG_HDR_SECOND: hdr_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-byte parse: field capture, checksum, forwarding and summary.
  always_comb begin
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    xor_nxt      = xor_r;
    hdr_ok_nxt   = hdr_ok_r;
    ctrl_nxt     = ctrl_r;
    func_nxt     = func_r;
    txn_nxt      = txn_r;
    chk_ok_nxt   = chk_ok_r;
    chk_seen_nxt = chk_seen_r;
    grp          = '0;
    in_range     = pos_r < MAX_POS;
    chk_pos      = {1'b0, PAYLOAD_START} + {1'b0, len_r};
    too_short    = in_range && (pos_r < (MIN_FRAME_BYTES - 16'd1));

    if (in_range) begin
      pos_nxt = pos_r + 16'd1;
      if (pos_r == POS_HDR0) begin
        hdr_ok_nxt = (byte_r == hdr_first_r);
      end else if (pos_r == POS_HDR1) begin
        hdr_ok_nxt = hdr_ok_r && (byte_r == hdr_second_r);
      end else if (pos_r == POS_LEN_HI) begin
        len_nxt = {byte_r, 8'h00};
        xor_nxt = xor_r ^ byte_r;
      end else if (pos_r == POS_LEN_LO) begin
        len_nxt = {len_r[15:8], byte_r};
        xor_nxt = xor_r ^ byte_r;
      end else if (pos_r == POS_CTRL) begin
        ctrl_nxt = byte_r;
        xor_nxt  = xor_r ^ byte_r;
      end else if (pos_r == POS_FUNC) begin
        func_nxt = byte_r;
        xor_nxt  = xor_r ^ byte_r;
      end else if (pos_r == POS_TXN) begin
        txn_nxt = byte_r;
        xor_nxt = xor_r ^ byte_r;
      end else if ({1'b0, pos_r} < chk_pos) begin
        xor_nxt     = xor_r ^ byte_r;
        grp.pay_v   = 1'b1;
        grp.payload = byte_r;
      end else if ({1'b0, pos_r} == chk_pos) begin
        chk_seen_nxt = 1'b1;
        chk_ok_nxt   = (byte_r == xor_r);
      end
    end

    // Summary uses the state as updated by this byte.
    grp.sum_v = fin_r;
    if (too_short) begin
      grp.summary.status = ST_TOO_SHORT;
    end else if (!hdr_ok_nxt) begin
      grp.summary.status = ST_BAD_HEADER;
    end else if (!chk_seen_nxt) begin
      grp.summary.status = ST_LEN_OVERRUN;
    end else if (!chk_ok_nxt) begin
      grp.summary.status = ST_BAD_CHECKSUM;
    end else begin
      grp.summary.status = ST_OK;
    end
    grp.summary.frame_type     = ctrl_nxt[7:6];
    grp.summary.report_kind    = kind_of_report(ctrl_nxt, func_nxt);
    grp.summary.function_code  = func_nxt;
    grp.summary.transaction_id = txn_nxt;
    grp.summary.payload_length = len_nxt;

    // The final byte returns the frame state to its reset values.
    if (fin_r) begin
      pos_nxt      = '0;
      len_nxt      = '0;
      xor_nxt      = '0;
      hdr_ok_nxt   = 1'b1;
      ctrl_nxt     = '0;
      func_nxt     = '0;
      txn_nxt      = '0;
      chk_ok_nxt   = 1'b0;
      chk_seen_nxt = 1'b0;
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      len_r      <= '0;
      xor_r      <= '0;
      hdr_ok_r   <= 1'b1;
      ctrl_r     <= '0;
      func_r     <= '0;
      txn_r      <= '0;
      chk_ok_r   <= 1'b0;
      chk_seen_r <= 1'b0;
    end else if (go) begin
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      xor_r      <= xor_nxt;
      hdr_ok_r   <= hdr_ok_nxt;
      ctrl_r     <= ctrl_nxt;
      func_r     <= func_nxt;
      txn_r      <= txn_nxt;
      chk_ok_r   <= chk_ok_nxt;
      chk_seen_r <= chk_seen_nxt;
    end
  end

  assign q_push = go && (grp.pay_v || grp.sum_v);
  assign q_grp  = grp;

`ifndef ASSERT_OFF
  // The position never runs past its bound.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MAX_POS)
    else $error("byte position beyond bound");

  // A processed final byte restarts the frame.
  a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (go && fin_r) |=> (pos_r == '0 && xor_r == '0 && hdr_ok_r))
    else $error("frame state not cleared after final byte");
`endif

endmodule

[sv/rfd_out_queue.sv]
module rfd_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_push,
  input  rfd_pkg::grp_t q_grp,
  output logic          q_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_item_kind,
  output logic [7:0]    out_payload_byte,
  output logic [2:0]    out_frame_status,
  output logic [1:0]    out_frame_type,
  output logic [2:0]    out_report_kind,
  output logic [7:0]    out_function_code,
  output logic [7:0]    out_transaction_id,
  output logic [15:0]   out_payload_length,
  output logic          out_last_of_run
);
  import rfd_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  grp_t             q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             half_r;

  grp_t head;
  logic emit_sum;
  logic item_last;
  logic beat;
  logic pop;

  assign q_ready   = cnt_r != CNT_W'(DEPTH);
  assign out_valid = cnt_r != '0;
  assign head      = q_r[rd_ptr_r];

  // A group with a payload byte and a summary goes out in two beats.
  assign emit_sum  = !head.pay_v || half_r;
  assign item_last = emit_sum || !head.sum_v;
  assign beat      = out_valid && out_ready;
  assign pop       = beat && item_last;

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_r[wr_ptr_r] <= q_grp;
    end
  end

  // Pointers, fill count and the second-beat flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      half_r   <= 1'b0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (q_push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !q_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (pop) begin
        half_r <= 1'b0;
      end else if (beat) begin
        half_r <= 1'b1;
      end
    end
  end

  // Result fields; the unused side of each item kind reads as zero.
  always_comb begin
    out_last_of_run = item_last;
    if (emit_sum) begin
      out_item_kind      = KIND_SUMMARY;
      out_payload_byte   = '0;
      out_frame_status   = head.summary.status;
      out_frame_type     = head.summary.frame_type;
      out_report_kind    = head.summary.report_kind;
      out_function_code  = head.summary.function_code;
      out_transaction_id = head.summary.transaction_id;
      out_payload_length = head.summary.payload_length;
    end else begin
      out_item_kind      = KIND_PAYLOAD;
      out_payload_byte   = head.payload;
      out_frame_status   = '0;
      out_frame_type     = '0;
      out_report_kind    = '0;
      out_function_code  = '0;
      out_transaction_id = '0;
      out_payload_length = '0;
    end
  end

`ifndef ASSERT_OFF
  // The fill count stays within the queue depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  // Every stored group carries at least one result.
  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (head.pay_v || head.sum_v))
    else $error("empty group at queue head");

  // The second beat only exists for a group holding both results.
  a_half_pair: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> (out_valid && head.pay_v && head.sum_v))
    else $error("second beat without a payload and summary pair");
`endif

endmodule
